// ===== hw/rtl/smallest_missing_value_tracker_assert.svh =====
// assertion macros for the smallest missing value tracker checker
// expects clk_i and rst_ni in the scope of each use
`ifndef SMALLEST_MISSING_VALUE_TRACKER_ASSERT_SVH
`define SMALLEST_MISSING_VALUE_TRACKER_ASSERT_SVH

// same-cycle implication
`define SMVT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smvt check failed");

// next-cycle implication
`define SMVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smvt check failed");

`endif

// ===== hw/rtl/smvt_pkg.sv =====
// shared constants and command codes of the smallest missing value tracker
// no dependencies
`timescale 1ns / 1ps

package smvt_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned VAL_W         = 16;
  localparam int unsigned MEX_W         = 11;
  localparam int unsigned LGST_W        = 10;
  localparam int unsigned EPOCH_W       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

endpackage

// ===== hw/rtl/smallest_missing_value_tracker.sv =====
// smallest missing value tracker: presence map in one synchronous memory
// depends on smvt_pkg
`timescale 1ns / 1ps

// Input channel (in_valid_i / in_ready_o) carries one word: command_i and value_i.
// Add marks an in-range value_i as present, clear empties the set, query only reports.
// Every word yields exactly one result word on the output channel
// (out_valid_o / out_ready_i) with the state after the command.
// The presence map holds one epoch tag per entry in a memory with a registered
// read port; an entry is present when its tag equals the current epoch, so a
// clear normally just bumps the epoch.
// Query, clear and most adds present their result in the cycle after acceptance, and
// the next word can be taken in the following cycle if the result drains and no
// clearing pass starts. An add of the current smallest missing value walks the
// memory one entry per cycle over the consecutive present entries above it, and
// no new word is taken until the walk has ended and its result is loaded.
// Each entry is walked at most once between clears.
// Reset starts a clearing pass over every entry (in_ready_o low); the same pass
// runs on the clear that wraps the epoch counter, once every 2**EPOCH_W - 1
// clears. When the receiver stalls, the result holds in the output register and
// one more word is still accepted only if the output register drains in the
// same cycle.
module smallest_missing_value_tracker #(
  parameter int unsigned DEPTH = smvt_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [smvt_pkg::CMD_W-1:0] command_i,
  input  logic signed [smvt_pkg::VAL_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [smvt_pkg::MEX_W-1:0] smallest_missing_o,
  output logic [smvt_pkg::LGST_W-1:0] largest_seen_o,
  output logic                       set_empty_o,
  output logic                       value_rejected_o
);
  import smvt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_END = PW'(DEPTH);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       largest_q, largest_d;
  logic                any_q, any_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [AW-1:0]       sweep_q, sweep_d;

  logic                out_valid_q, out_valid_d;
  logic [MEX_W-1:0]    mex_q, mex_d;
  logic [LGST_W-1:0]   lgst_q, lgst_d;
  logic                empty_q, empty_d;
  logic                rej_q, rej_d;

  logic [EPOCH_W-1:0]  mem [DEPTH];
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [EPOCH_W-1:0]  mem_wdata;
  logic [EPOCH_W-1:0]  rd_tag_q;

  logic                accept, slot_free, load_out, res_rej;
  logic                is_add, is_clear, val_nonneg, val_fits;
  logic [31:0]         val_ext, ptr_w, lgst_w;
  logic [AW-1:0]       val_idx;
  logic [PW-1:0]       ptr_inc;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  assign is_add     = (command_i == CMD_ADD);
  assign is_clear   = (command_i == CMD_CLEAR);
  assign val_ext    = {{(32 - VAL_W){1'b0}}, value_i};
  assign val_nonneg = !value_i[VAL_W-1];
  assign val_fits   = val_nonneg && (val_ext < DEPTH);
  assign val_idx    = val_ext[AW-1:0];
  assign ptr_inc    = ptr_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    largest_d   = largest_q;
    any_d       = any_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    mem_we      = 1'b0;
    mem_waddr   = val_idx;
    mem_wdata   = epoch_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_inc[AW-1:0];
    load_out    = 1'b0;
    res_rej     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) begin
          sweep_d = '0;
          epoch_d = EPOCH_W'(1);
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (is_add) begin
            if (val_fits) begin
              mem_we = 1'b1;
              any_d  = 1'b1;
              if (!any_q || (val_idx > largest_q)) begin
                largest_d = val_idx;
              end
              if (ptr_q == PW'(val_idx)) begin
                ptr_d = ptr_inc;
                if (ptr_inc != PTR_END) begin
                  mem_re  = 1'b1;
                  state_d = S_WALK;
                end else begin
                  load_out = 1'b1;
                end
              end else begin
                load_out = 1'b1;
              end
            end else begin
              res_rej  = val_nonneg;
              load_out = 1'b1;
            end
          end else if (is_clear) begin
            ptr_d     = '0;
            largest_d = '0;
            any_d     = 1'b0;
            load_out  = 1'b1;
            if (epoch_q == '1) begin
              state_d = S_SWEEP;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      S_WALK: begin
        if ((rd_tag_q == epoch_q) && (ptr_inc != PTR_END)) begin
          ptr_d  = ptr_inc;
          mem_re = 1'b1;
        end else begin
          // entry missing, or last entry present
          if (rd_tag_q == epoch_q) begin
            ptr_d = ptr_inc;
          end
          if (slot_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    ptr_w  = 32'(ptr_d);
    lgst_w = 32'(largest_d);
    mex_d   = mex_q;
    lgst_d  = lgst_q;
    empty_d = empty_q;
    rej_d   = rej_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      mex_d       = ptr_w[MEX_W-1:0];
      lgst_d      = any_d ? lgst_w[LGST_W-1:0] : '0;
      empty_d     = !any_d;
      rej_d       = res_rej;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      ptr_q       <= '0;
      largest_q   <= '0;
      any_q       <= 1'b0;
      epoch_q     <= EPOCH_W'(1);
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      mex_q       <= '0;
      lgst_q      <= '0;
      empty_q     <= 1'b1;
      rej_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      largest_q   <= largest_d;
      any_q       <= any_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      mex_q       <= mex_d;
      lgst_q      <= lgst_d;
      empty_q     <= empty_d;
      rej_q       <= rej_d;
    end
  end

  // presence tags, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_tag_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign smallest_missing_o = mex_q;
  assign largest_seen_o     = lgst_q;
  assign set_empty_o        = empty_q;
  assign value_rejected_o   = rej_q;

endmodule

// ===== hw/rtl/smvt_checker.sv =====
// port-level checks for the smallest missing value tracker, bound to the top level
// depends on smvt_pkg and smallest_missing_value_tracker_assert.svh
`timescale 1ns / 1ps
`include "smallest_missing_value_tracker_assert.svh"

module smvt_checker #(
  parameter int unsigned DEPTH = smvt_pkg::DEPTH_DEFAULT
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [smvt_pkg::CMD_W-1:0]  command_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [smvt_pkg::MEX_W-1:0]  smallest_missing_o,
  input logic [smvt_pkg::LGST_W-1:0] largest_seen_o,
  input logic                        set_empty_o
);
  import smvt_pkg::*;

  // stalled result word holds
  `SMVT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(smallest_missing_o) && $stable(largest_seen_o) && $stable(set_empty_o))

  // empty set reports zero for both values
  `SMVT_ASSERT(a_empty_zero, out_valid_o && set_empty_o, (smallest_missing_o == '0) && (largest_seen_o == '0))

  // pointer never runs past the map
  `SMVT_ASSERT(a_mex_bound, out_valid_o, 32'(smallest_missing_o) <= DEPTH)

  // accepted clear answers with an empty set in the next cycle
  `SMVT_ASSERT_NEXT(a_clear_empty, in_valid_i && in_ready_o && (command_i == CMD_CLEAR), out_valid_o && set_empty_o)

endmodule

bind smallest_missing_value_tracker smvt_checker #(.DEPTH(DEPTH)) u_smvt_checker (.*);

// ===== test/smallest_missing_value_tracker_checker.sv =====
// result checker for the smallest missing value tracker: keeps its own presence map,
// predicts one result word per accepted command word and compares in order
// depends on smvt_pkg
`timescale 1ns / 1ps

module smallest_missing_value_tracker_checker #(
  parameter int unsigned DEPTH = smvt_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [smvt_pkg::CMD_W-1:0]         command_i,
  input  logic signed [smvt_pkg::VAL_W-1:0]  value_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [smvt_pkg::MEX_W-1:0]         smallest_missing_i,
  input  logic [smvt_pkg::LGST_W-1:0]        largest_seen_i,
  input  logic                               set_empty_i,
  input  logic                               value_rejected_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import smvt_pkg::*;

  typedef struct packed {
    logic [MEX_W-1:0]  smallest_missing;
    logic [LGST_W-1:0] largest_seen;
    logic              set_empty;
    logic              value_rejected;
  } mex_result_t;

  bit          seen_map [DEPTH];
  logic [31:0] mex_ptr;
  logic [31:0] top_value;
  bit          have_value;
  mex_result_t expected_words [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void wipe_map();
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    mex_ptr    = '0;
    top_value  = '0;
    have_value = 1'b0;
  endfunction

  function automatic mex_result_t apply_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
    mex_result_t res;
    bit          rejected;
    rejected = 1'b0;
    if (cmd == CMD_ADD) begin
      if (!val[VAL_W-1]) begin
        if (val >= DEPTH) begin
          rejected = 1'b1;
        end else begin
          seen_map[val] = 1'b1;
          if (!have_value || val > top_value) top_value = val;
          have_value = 1'b1;
        end
      end
      while (mex_ptr < DEPTH && seen_map[mex_ptr]) mex_ptr++;
    end else if (cmd == CMD_CLEAR) begin
      wipe_map();
    end
    res.smallest_missing = mex_ptr[MEX_W-1:0];
    res.largest_seen     = have_value ? top_value[LGST_W-1:0] : '0;
    res.set_empty        = !have_value;
    res.value_rejected   = rejected;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mex_result_t exp_w;
    if (!rst_ni) begin
      wipe_map();
      expected_words.delete();
      pending_o = 0;
    end else begin
      // drain first so a result is never matched to the word taken in the same cycle
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing outstanding", 0, 1);
        end else begin
          exp_w = expected_words.pop_front();
          if (smallest_missing_i !== exp_w.smallest_missing)
            report_mismatch("smallest_missing", exp_w.smallest_missing, smallest_missing_i);
          if (largest_seen_i !== exp_w.largest_seen)
            report_mismatch("largest_seen", exp_w.largest_seen, largest_seen_i);
          if (set_empty_i !== exp_w.set_empty)
            report_mismatch("set_empty", exp_w.set_empty, set_empty_i);
          if (value_rejected_i !== exp_w.value_rejected)
            report_mismatch("value_rejected", exp_w.value_rejected, value_rejected_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_words.insert(expected_words.size(), apply_word(command_i, value_i));
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== test/tb_smallest_missing_value_tracker.sv =====
// testbench top for the smallest missing value tracker: drives command words with
// random gaps and receiver stalls, the checker beside the block predicts and compares
// depends on smvt_pkg, smallest_missing_value_tracker and its checker
`timescale 1ns / 1ps

module tb_smallest_missing_value_tracker;

  import smvt_pkg::*;

  localparam int unsigned     DEPTH        = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_SPARE    = 2'd3;
  localparam int              RANDOM_WORDS = 220;
  localparam int              FILL_TOP     = 191;
  localparam int              IDLE_LIMIT   = 12000;
  localparam int              HOLD_CYCLES  = 400;
  localparam int              HOLD_AT      = 100;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          command = CMD_QUERY;
  logic signed [VAL_W-1:0]   value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [MEX_W-1:0]          smallest_missing;
  logic [LGST_W-1:0]         largest_seen;
  logic                      set_empty;
  logic                      value_rejected;
  int                        fail_count;
  int                        pending;
  bit                        steady = 1'b0;
  int                        results_taken = 0;

  smallest_missing_value_tracker #(.DEPTH(DEPTH)) u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (command),
    .value_i            (value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .smallest_missing_o (smallest_missing),
    .largest_seen_o     (largest_seen),
    .set_empty_o        (set_empty),
    .value_rejected_o   (value_rejected)
  );

  smallest_missing_value_tracker_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .command_i          (command),
    .value_i            (value),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .smallest_missing_i (smallest_missing),
    .largest_seen_i     (largest_seen),
    .set_empty_i        (set_empty),
    .value_rejected_i   (value_rejected),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
    int gap;
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = steady ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: ready runs and stalls, plus one long hold-off
  initial begin
    int  run;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      for (int i = 0; i < run; i++) begin
        @(posedge clk);
        if (out_valid && out_ready) results_taken++;
      end
      if (!held && results_taken >= HOLD_AT) begin
        held = 1'b1;
        run  = HOLD_CYCLES;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
      out_ready <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("smallest_missing_value_tracker verification failed");
    $finish;
  end

  initial begin
    int n;
    int r;
    int len;
    int base;
    int win;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    push_word(CMD_QUERY, 16'sd0);
    push_word(CMD_ADD, 16'sd0);
    push_word(CMD_ADD, 16'sd2);
    push_word(CMD_ADD, 16'sd1);
    push_word(CMD_ADD, 16'sd1);
    push_word(CMD_ADD, 16'shFFFF);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_ADD, 16'sd1024);
    push_word(CMD_ADD, 16'sh7FFF);
    push_word(CMD_ADD, 16'sd1023);
    push_word(CMD_QUERY, 16'sh7FFF);
    push_word(CMD_SPARE, 16'sd5);
    push_word(CMD_CLEAR, 16'shFFFF);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_QUERY, 16'sd0);
    push_word(CMD_ADD, 16'sd5);
    push_word(CMD_CLEAR, 16'sd0);
    push_word(CMD_SPARE, 16'sh8000);

    // fill the low end of the map from the top so the last add walks every filled entry
    for (int v = FILL_TOP; v >= 0; v--) push_word(CMD_ADD, 16'(v));
    push_word(CMD_ADD, 16'(DEPTH - 1));
    push_word(CMD_ADD, 16'sd0);
    push_word(CMD_ADD, 16'(DEPTH));
    push_word(CMD_QUERY, 16'sd0);
    push_word(CMD_CLEAR, 16'sd0);

    // enough clears in a row to wrap the epoch
    repeat (15) push_word(CMD_CLEAR, 16'sd0);

    n = 0;
    while (n < RANDOM_WORDS) begin
      steady = (n >= 100 && n < 160);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // descending run, mostly lands right above the pointer
        len  = $urandom_range(3, 30);
        base = $urandom_range(0, 100);
        for (int k = len; k >= 0; k--) push_word(CMD_ADD, 16'(base + k));
        n += len + 1;
      end else begin
        r   = $urandom_range(0, 99);
        win = $urandom_range(8, 160);
        if (r < 55)      push_word(CMD_ADD, 16'($urandom_range(0, win)));
        else if (r < 62) push_word(CMD_ADD, 16'($urandom()));
        else if (r < 68) push_word(CMD_ADD, 16'($urandom_range(DEPTH - 64, DEPTH - 1)));
        else if (r < 72) push_word(CMD_ADD, 16'($urandom_range(DEPTH, 32767)));
        else if (r < 78) push_word(CMD_ADD, 16'($urandom_range(32768, 65535)));
        else if (r < 86) push_word(CMD_CLEAR, 16'($urandom()));
        else if (r < 97) push_word(CMD_QUERY, 16'($urandom()));
        else             push_word(CMD_SPARE, 16'($urandom()));
        n++;
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("smallest_missing_value_tracker verification clean");
    end else begin
      $display("smallest_missing_value_tracker verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/smvt_pkg.sv
hw/rtl/smallest_missing_value_tracker.sv
hw/rtl/smvt_checker.sv
test/smallest_missing_value_tracker_checker.sv
test/tb_smallest_missing_value_tracker.sv
